>>> hw/rtl/mdm_pkg.sv
// ----------------------------------------------------------------------------
// mdm_pkg
// Shared constants, codes and controller/datapath interface types for the
// multi-pattern nucleotide matcher.
// ----------------------------------------------------------------------------
package mdm_pkg;

  // Sizes of the automaton.
  localparam int NODES  = 1024;
  localparam int NW     = $clog2(NODES);
  localparam int CNT_W  = NW + 1;
  localparam int PATS   = 10;
  localparam int PC_W   = $clog2(PATS + 1);
  localparam int PI_W   = $clog2(PATS);
  localparam int SYMS   = 4;
  localparam int SYM_W  = 2;
  localparam int WT_W   = 11;
  localparam int SC_W   = 15;
  localparam int MODE_W = 3;
  localparam int ERR_W  = 2;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_SYM   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_END   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BUILD = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MATCH = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NODES = 2'd1;
  localparam logic [ERR_W-1:0] ERR_PATS  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_LINKS = 2'd3;

  // Micro-operations issued by the controller to the datapath.
  typedef enum logic [4:0] {
    OP_NOP, OP_CLR, OP_LOAD, OP_DISP, OP_P0, OP_E0, OP_E1,
    OP_MRD, OP_MCHK, OP_MMASK, OP_MSEEN,
    OP_BINIT, OP_BPOP, OP_BNOW, OP_BROW, OP_BSYM, OP_BFRD, OP_BFCHK,
    OP_BSET, OP_BMF, OP_BMC, OP_BNEXT, OP_BDONE,
    OP_FRD, OP_SCORE, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              links;
    logic              pc_full;
    logic              clr_last;
    logic              m_stop;
    logic              q_empty;
    logic              root_now;
    logic              c_zero;
    logic              f_stop;
    logic              s_last;
    logic              score_last;
    logic              out_free;
  } stat_t;

endpackage

>>> hw/rtl/mdm_ctrl.sv
// ----------------------------------------------------------------------------
// mdm_ctrl
// Sequencer that steps the datapath through clearing, loading, link
// building, matching and result scoring.
// ----------------------------------------------------------------------------
module mdm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mdm_pkg::stat_t stat,
  output mdm_pkg::cmd_t  cmd
);
  import mdm_pkg::*;

  typedef enum logic [24:0] {
    ST_CLEAR = 25'd1 << 0,  ST_IDLE  = 25'd1 << 1,  ST_DISP  = 25'd1 << 2,
    ST_P0    = 25'd1 << 3,  ST_E0    = 25'd1 << 4,  ST_E1    = 25'd1 << 5,
    ST_MRD   = 25'd1 << 6,  ST_MCHK  = 25'd1 << 7,  ST_MMASK = 25'd1 << 8,
    ST_MSEEN = 25'd1 << 9,  ST_BINIT = 25'd1 << 10, ST_BPOP  = 25'd1 << 11,
    ST_BNOW  = 25'd1 << 12, ST_BROW  = 25'd1 << 13, ST_BSYM  = 25'd1 << 14,
    ST_BFRD  = 25'd1 << 15, ST_BFCHK = 25'd1 << 16, ST_BSET  = 25'd1 << 17,
    ST_BMF   = 25'd1 << 18, ST_BMC   = 25'd1 << 19, ST_BNEXT = 25'd1 << 20,
    ST_BDONE = 25'd1 << 21, ST_FRD   = 25'd1 << 22, ST_SCORE = 25'd1 << 23,
    ST_EMIT  = 25'd1 << 24
  } state_t;

  state_t state, state_next;
  logic   clr_item, clr_item_next;

  assign in_ready = (state == ST_IDLE);

  // State register; reset starts with a clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_item <= 1'b0;
    end else begin
      state    <= state_next;
      clr_item <= clr_item_next;
    end
  end

  // Next state and command.
  always_comb begin
    state_next    = state;
    clr_item_next = clr_item;
    cmd.op        = OP_NOP;
    unique case (state)
      ST_CLEAR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) begin
          state_next    = clr_item ? ST_FRD : ST_IDLE;
          clr_item_next = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_DISP;
        end
      end
      ST_DISP: begin
        cmd.op = OP_DISP;
        priority if (stat.mode == MODE_SYM) begin
          state_next = ST_P0;
        end else if (stat.mode == MODE_END) begin
          state_next = stat.pc_full ? ST_FRD : ST_E0;
        end else if (stat.mode == MODE_BUILD) begin
          state_next = ST_BINIT;
        end else if (stat.mode == MODE_MATCH) begin
          state_next = stat.links ? ST_MRD : ST_FRD;
        end else if (stat.mode == MODE_CLEAR) begin
          state_next    = ST_CLEAR;
          clr_item_next = 1'b1;
        end else begin
          state_next = ST_FRD;
        end
      end
      ST_P0: begin
        cmd.op     = OP_P0;
        state_next = ST_FRD;
      end
      ST_E0: begin
        cmd.op     = OP_E0;
        state_next = ST_E1;
      end
      ST_E1: begin
        cmd.op     = OP_E1;
        state_next = ST_FRD;
      end
      ST_MRD: begin
        cmd.op     = OP_MRD;
        state_next = ST_MCHK;
      end
      ST_MCHK: begin
        cmd.op     = OP_MCHK;
        state_next = stat.m_stop ? ST_MMASK : ST_MRD;
      end
      ST_MMASK: begin
        cmd.op     = OP_MMASK;
        state_next = ST_MSEEN;
      end
      ST_MSEEN: begin
        cmd.op     = OP_MSEEN;
        state_next = ST_FRD;
      end
      ST_BINIT: begin
        cmd.op     = OP_BINIT;
        state_next = ST_BPOP;
      end
      ST_BPOP: begin
        if (stat.q_empty) begin
          state_next = ST_BDONE;
        end else begin
          cmd.op     = OP_BPOP;
          state_next = ST_BNOW;
        end
      end
      ST_BNOW: begin
        cmd.op     = OP_BNOW;
        state_next = ST_BROW;
      end
      ST_BROW: begin
        cmd.op     = OP_BROW;
        state_next = ST_BSYM;
      end
      ST_BSYM: begin
        cmd.op = OP_BSYM;
        priority if (stat.c_zero) begin
          state_next = ST_BNEXT;
        end else if (stat.root_now) begin
          state_next = ST_BSET;
        end else begin
          state_next = ST_BFRD;
        end
      end
      ST_BFRD: begin
        cmd.op     = OP_BFRD;
        state_next = ST_BFCHK;
      end
      ST_BFCHK: begin
        cmd.op     = OP_BFCHK;
        state_next = stat.f_stop ? ST_BSET : ST_BFRD;
      end
      ST_BSET: begin
        cmd.op     = OP_BSET;
        state_next = ST_BMF;
      end
      ST_BMF: begin
        cmd.op     = OP_BMF;
        state_next = ST_BMC;
      end
      ST_BMC: begin
        cmd.op     = OP_BMC;
        state_next = ST_BNEXT;
      end
      ST_BNEXT: begin
        cmd.op     = OP_BNEXT;
        state_next = stat.s_last ? ST_BPOP : ST_BSYM;
      end
      ST_BDONE: begin
        cmd.op     = OP_BDONE;
        state_next = ST_FRD;
      end
      ST_FRD: begin
        cmd.op     = OP_FRD;
        state_next = ST_SCORE;
      end
      ST_SCORE: begin
        cmd.op = OP_SCORE;
        if (stat.score_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

>>> hw/rtl/mdm_datapath.sv
// ----------------------------------------------------------------------------
// mdm_datapath
// Trie, failure and mask tables, breadth-first queue, cursors and the
// result register, driven one micro-operation per cycle.
// ----------------------------------------------------------------------------
module mdm_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  mdm_pkg::cmd_t                cmd,
  output mdm_pkg::stat_t               stat,
  input  logic [mdm_pkg::MODE_W-1:0]   in_mode,
  input  logic [mdm_pkg::SYM_W-1:0]    in_symbol,
  input  logic signed [mdm_pkg::WT_W-1:0] in_weight,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mdm_pkg::NW-1:0]       out_node,
  output logic [mdm_pkg::PATS-1:0]     out_node_mask,
  output logic [mdm_pkg::PATS-1:0]     out_seen_mask,
  output logic signed [mdm_pkg::SC_W-1:0] out_score,
  output logic [mdm_pkg::ERR_W-1:0]    out_error
);
  import mdm_pkg::*;

  typedef logic [SYMS-1:0][NW-1:0] row_t;

  // Memories with registered read data.
  row_t             child_mem [NODES];
  logic [NW-1:0]    fail_mem  [NODES];
  logic [PATS-1:0]  mask_mem  [NODES];
  logic [NW-1:0]    queue_mem [NODES];
  row_t             child_q;
  logic [NW-1:0]    fail_q;
  logic [PATS-1:0]  mask_q;
  logic [NW-1:0]    queue_q;

  logic             child_we, child_re, fail_we, fail_re, mask_we, mask_re;
  logic             queue_we, queue_re;
  logic [NW-1:0]    child_wa, child_ra, fail_wa, fail_ra, mask_wa, mask_ra;
  logic [NW-1:0]    queue_wa, queue_ra, fail_wd, queue_wd;
  row_t             child_wd;
  logic [PATS-1:0]  mask_wd;

  // Item and walk registers.
  logic [MODE_W-1:0]      mode;
  logic [SYM_W-1:0]       symbol;
  logic signed [WT_W-1:0] weight;
  logic signed [WT_W-1:0] weights [PATS];
  logic [NW-1:0]          cursor, match, p, now, fail_now, c_reg, f_reg, node_out;
  logic [NW-1:0]          clr_addr;
  logic [CNT_W-1:0]       node_count, head, tail;
  logic [PC_W-1:0]        pat_count;
  logic                   links;
  logic [PATS-1:0]        seen, mask_f;
  row_t                   row_now;
  logic [SYM_W-1:0]       s;
  logic [PI_W-1:0]        si;
  logic signed [SC_W-1:0] acc;
  logic [ERR_W-1:0]       err;

  logic [NW-1:0]          kid_cur, kid_fl;
  logic                   p0_new;

  assign kid_cur = child_q[symbol];
  assign kid_fl  = child_q[s];
  assign p0_new  = (kid_cur == '0) && (node_count < CNT_W'(NODES));

  // Status toward the controller.
  always_comb begin
    stat.mode       = mode;
    stat.links      = links;
    stat.pc_full    = (pat_count >= PC_W'(PATS));
    stat.clr_last   = (clr_addr == NW'(NODES - 1));
    stat.m_stop     = (kid_cur != '0) || (p == '0);
    stat.q_empty    = (head >= tail);
    stat.root_now   = (now == '0);
    stat.c_zero     = (row_now[s] == '0);
    stat.f_stop     = (kid_fl != '0) || (p == '0);
    stat.s_last     = (s == SYM_W'(SYMS - 1));
    stat.score_last = (si == PI_W'(PATS - 1));
    stat.out_free   = !out_valid || out_ready;
  end

  // Memory port selection by micro-operation.
  always_comb begin
    child_we = 1'b0; child_re = 1'b0; fail_we = 1'b0; fail_re = 1'b0;
    mask_we  = 1'b0; mask_re  = 1'b0; queue_we = 1'b0; queue_re = 1'b0;
    child_wa = clr_addr; child_ra = p; child_wd = '0;
    fail_wa  = clr_addr; fail_ra  = p; fail_wd  = '0;
    mask_wa  = clr_addr; mask_ra  = node_out; mask_wd = '0;
    queue_wa = tail[NW-1:0]; queue_ra = head[NW-1:0]; queue_wd = c_reg;
    unique case (cmd.op)
      OP_CLR: begin
        child_we = 1'b1; fail_we = 1'b1; mask_we = 1'b1;
      end
      OP_DISP: begin
        child_re = 1'b1; child_ra = cursor;
      end
      OP_P0: begin
        child_we          = p0_new;
        child_wa          = cursor;
        child_wd          = child_q;
        child_wd[symbol]  = node_count[NW-1:0];
      end
      OP_E0: begin
        mask_re = 1'b1; mask_ra = cursor;
      end
      OP_E1: begin
        mask_we = 1'b1; mask_wa = cursor;
        mask_wd = mask_q | (PATS'(1) << pat_count);
      end
      OP_MRD, OP_BFRD: begin
        child_re = 1'b1; fail_re = 1'b1;
      end
      OP_MMASK: begin
        mask_re = 1'b1; mask_ra = match;
      end
      OP_BINIT: begin
        queue_we = 1'b1; queue_wa = '0; queue_wd = '0;
      end
      OP_BPOP: begin
        queue_re = 1'b1;
      end
      OP_BNOW: begin
        child_re = 1'b1; child_ra = queue_q;
        fail_re  = 1'b1; fail_ra  = queue_q;
      end
      OP_BSET: begin
        fail_we = 1'b1; fail_wa = c_reg; fail_wd = f_reg;
        mask_re = 1'b1; mask_ra = f_reg;
      end
      OP_BMF: begin
        mask_re = 1'b1; mask_ra = c_reg;
      end
      OP_BMC: begin
        mask_we  = 1'b1; mask_wa = c_reg; mask_wd = mask_q | mask_f;
        queue_we = (tail < CNT_W'(NODES));
      end
      OP_FRD: begin
        mask_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Memory arrays.
  always_ff @(posedge clk) begin
    if (child_we) child_mem[child_wa] <= child_wd;
    if (child_re) child_q <= child_mem[child_ra];
  end

  always_ff @(posedge clk) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    if (fail_re) fail_q <= fail_mem[fail_ra];
  end

  always_ff @(posedge clk) begin
    if (mask_we) mask_mem[mask_wa] <= mask_wd;
    if (mask_re) mask_q <= mask_mem[mask_ra];
  end

  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    if (queue_re) queue_q <= queue_mem[queue_ra];
  end

  // Control state of the automaton.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      cursor     <= '0;
      match      <= '0;
      seen       <= '0;
      node_count <= CNT_W'(1);
      pat_count  <= '0;
      links      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_ready && cmd.op != OP_EMIT) out_valid <= 1'b0;
      unique case (cmd.op)
        OP_CLR: begin
          clr_addr   <= clr_addr + NW'(1);
          cursor     <= '0;
          match      <= '0;
          seen       <= '0;
          node_count <= CNT_W'(1);
          pat_count  <= '0;
          links      <= 1'b0;
        end
        OP_P0: begin
          if (kid_cur != '0) begin
            cursor <= kid_cur;
            links  <= 1'b0;
          end else if (p0_new) begin
            cursor     <= node_count[NW-1:0];
            node_count <= node_count + CNT_W'(1);
            links      <= 1'b0;
          end
        end
        OP_E1: begin
          pat_count <= pat_count + PC_W'(1);
          cursor    <= '0;
          links     <= 1'b0;
        end
        OP_MCHK: begin
          if (stat.m_stop) match <= (kid_cur != '0) ? kid_cur : p;
        end
        OP_MSEEN: begin
          seen <= seen | mask_q;
        end
        OP_BDONE: begin
          links <= 1'b1;
        end
        OP_EMIT: begin
          out_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers of the walk and the result.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        mode   <= in_mode;
        symbol <= in_symbol;
        weight <= in_weight;
      end
      OP_DISP: begin
        p        <= match;
        err      <= ERR_OK;
        node_out <= match;
        if (mode == MODE_SYM || mode == MODE_END) node_out <= cursor;
        if (mode == MODE_BUILD || mode == MODE_CLEAR) node_out <= '0;
        if (mode == MODE_END && stat.pc_full) err <= ERR_PATS;
        if (mode == MODE_MATCH && !links) err <= ERR_LINKS;
      end
      OP_P0: begin
        if (kid_cur != '0) begin
          node_out <= kid_cur;
        end else if (p0_new) begin
          node_out <= node_count[NW-1:0];
        end else begin
          err <= ERR_NODES;
        end
      end
      OP_E1: begin
        weights[pat_count[PI_W-1:0]] <= weight;
      end
      OP_MCHK: begin
        if (!stat.m_stop) p <= fail_q;
      end
      OP_MSEEN: begin
        node_out <= match;
      end
      OP_BINIT: begin
        head <= '0;
        tail <= CNT_W'(1);
      end
      OP_BPOP: begin
        head <= head + CNT_W'(1);
      end
      OP_BNOW: begin
        now <= queue_q;
      end
      OP_BROW: begin
        row_now  <= child_q;
        fail_now <= fail_q;
        s        <= '0;
      end
      OP_BSYM: begin
        c_reg <= row_now[s];
        f_reg <= '0;
        p     <= fail_now;
      end
      OP_BFCHK: begin
        if (kid_fl != '0) begin
          f_reg <= kid_fl;
        end else if (p != '0) begin
          p <= fail_q;
        end
      end
      OP_BMF: begin
        mask_f <= mask_q;
      end
      OP_BMC: begin
        if (tail < CNT_W'(NODES)) tail <= tail + CNT_W'(1);
      end
      OP_BNEXT: begin
        s <= s + SYM_W'(1);
      end
      OP_FRD: begin
        acc <= '0;
        si  <= '0;
      end
      OP_SCORE: begin
        if (seen[si]) begin
          acc <= acc + {{(SC_W - WT_W){weights[si][WT_W-1]}}, weights[si]};
        end
        si <= si + PI_W'(1);
      end
      OP_EMIT: begin
        out_node      <= node_out;
        out_node_mask <= mask_q;
        out_seen_mask <= seen;
        out_score     <= acc;
        out_error     <= err;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/multi_pattern_dna_matcher_top.sv
// Items are taken one at a time, and the work on one depends on its mode.
// Ending a pattern does less work when every pattern slot is taken, a match
// step follows failure links until a child is found or the root is reached
// (and skips the walk before the links are built), building the links visits
// every trie node in breadth-first order and probes failure links for the
// children of non-root nodes, and clearing sweeps all 1024 table rows to zero.
// A new item is taken only after the result of the one before is offered.
// The score is summed over the ten pattern weights, one per cycle. After
// reset the block sweeps all 1024 table rows to zero before it accepts the
// first item.
// ----------------------------------------------------------------------------
// multi_pattern_dna_matcher_top
// Multi-pattern matcher over the nucleotide alphabet with failure links.
// ----------------------------------------------------------------------------
module multi_pattern_dna_matcher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // symbol[1:0], weight[12:2], zero pad
  input  logic [2:0]  s_axis_tuser,  // mode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // node, node_mask, seen_mask, score, pad
  output logic [1:0]  m_axis_tuser   // error[1:0]
);
  import mdm_pkg::*;

  cmd_t                   cmd;
  stat_t                  stat;
  logic [NW-1:0]          node;
  logic [PATS-1:0]        node_mask, seen_mask;
  logic signed [SC_W-1:0] score;

  mdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mdm_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_mode       (s_axis_tuser),
    .in_symbol     (s_axis_tdata[1:0]),
    .in_weight     (s_axis_tdata[12:2]),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_node      (node),
    .out_node_mask (node_mask),
    .out_seen_mask (seen_mask),
    .out_score     (score),
    .out_error     (m_axis_tuser)
  );

  // Output beat packing.
  assign m_axis_tdata = {3'b000, score, seen_mask, node_mask, node};

  // The table sweep after reset holds off input.
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !s_axis_tready)
    else $error("input taken during clearing pass");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in work");

  // A fresh result never overwrites one still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT |-> !m_axis_tvalid || m_axis_tready)
    else $error("result overwritten before it was taken");

endmodule

>>> tb/multi_pattern_dna_matcher_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_pattern_dna_matcher_top_tb
// Self-checking bench for the multi-pattern matcher. Items go in on the
// slave stream, and each result beat is compared with the output of an
// automaton model kept inside the bench. A directed table comes first. The
// random part loads patterns, builds the links and scans text, with one pass
// that fills the node table. The phases run with and without idling on
// either side.
// ----------------------------------------------------------------------------
module multi_pattern_dna_matcher_top_tb;
  import mdm_pkg::*;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [SYM_W-1:0]  sym;
    logic [WT_W-1:0]   wt;
  } item_t;

  typedef struct {
    logic [NW-1:0]    node;
    logic [NW-1:0]    nmask;
    logic [NW-1:0]    seen;
    logic [SC_W-1:0]  score;
    logic [ERR_W-1:0] err;
  } beat_t;

  typedef struct {
    item_t in;
    bit    fixed;
    beat_t res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  multi_pattern_dna_matcher_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Automaton state mirrored by the bench.
  logic [NW-1:0]   trie_kid [NODES*SYMS];
  logic [NW-1:0]   fail_of [NODES];
  logic [NW-1:0]   pat_mask [NODES];
  logic [WT_W-1:0] pat_wt [PATS];
  int              nodes_used, pats_used;
  logic [NW-1:0]   cursor, here, seen_acc;
  bit              linked;

  item_t  feed_q [$];
  beat_t  due_q [$];
  bit     fixed_q [$];
  beat_t  fixed_res_q [$];
  item_t  cur_item;
  bit     cur_fixed;
  beat_t  cur_res;
  int     idle_pct = 0, stall_pct = 0;
  int     errors = 0;
  int     cycles = 0;

  task automatic wipe_automaton();
    for (int i = 0; i < NODES*SYMS; i++) trie_kid[i] = '0;
    for (int i = 0; i < NODES; i++) begin
      fail_of[i] = '0;
      pat_mask[i] = '0;
    end
    for (int i = 0; i < PATS; i++) pat_wt[i] = '0;
    nodes_used = 1;
    pats_used = 0;
    cursor = '0;
    here = '0;
    seen_acc = '0;
    linked = 0;
  endtask

  // Failure links breadth-first, merging each node's mask with its target's.
  task automatic link_automaton();
    int bq [NODES];
    int head, tail, now, c, f, p;
    head = 0;
    tail = 1;
    bq[0] = 0;
    fail_of[0] = '0;
    while (head < tail) begin
      now = bq[head];
      head++;
      for (int s = 0; s < SYMS; s++) begin
        c = int'(trie_kid[now*SYMS+s]);
        f = 0;
        if (c == 0) continue;
        if (now != 0) begin
          p = int'(fail_of[now]);
          for (int g = 0; g < NODES; g++) begin
            if (trie_kid[p*SYMS+s] != 0) begin
              f = int'(trie_kid[p*SYMS+s]);
              break;
            end
            if (p == 0) break;
            p = int'(fail_of[p]);
          end
        end
        fail_of[c] = NW'(f);
        pat_mask[c] = pat_mask[c] | pat_mask[f];
        if (tail < NODES) begin
          bq[tail] = c;
          tail++;
        end
      end
    end
    linked = 1;
  endtask

  function automatic logic [SC_W-1:0] weight_sum(logic [NW-1:0] m);
    int sum;
    sum = 0;
    for (int i = 0; i < PATS && i < pats_used; i++)
      if (m[i]) sum += $signed(pat_wt[i]);
    if (sum > 16383) sum = 16383;
    if (sum < -16384) sum = -16384;
    return sum[SC_W-1:0];
  endfunction

  // Apply one item to the automaton and return the beat it should produce.
  task automatic step_automaton(input item_t it, output beat_t r);
    int c, p;
    logic [NW-1:0] rep;
    r.err = ERR_OK;
    rep = here;
    case (it.mode)
      MODE_SYM: begin
        c = int'(trie_kid[cursor*SYMS+it.sym]);
        if (c == 0) begin
          if (nodes_used >= NODES) r.err = ERR_NODES;
          else begin
            c = nodes_used;
            nodes_used++;
            trie_kid[cursor*SYMS+it.sym] = NW'(c);
          end
        end
        if (c != 0) begin
          cursor = NW'(c);
          linked = 0;
        end
        rep = cursor;
      end
      MODE_END: begin
        rep = cursor;
        if (pats_used >= PATS) r.err = ERR_PATS;
        else begin
          pat_mask[cursor][pats_used] = 1'b1;
          pat_wt[pats_used] = it.wt;
          pats_used++;
          cursor = '0;
          linked = 0;
        end
      end
      MODE_BUILD: begin
        link_automaton();
        rep = '0;
      end
      MODE_MATCH: begin
        if (!linked) r.err = ERR_LINKS;
        else begin
          p = int'(here);
          for (int g = 0; g < NODES; g++) begin
            if (trie_kid[p*SYMS+it.sym] != 0 || p == 0) break;
            p = int'(fail_of[p]);
          end
          if (trie_kid[p*SYMS+it.sym] != 0) p = int'(trie_kid[p*SYMS+it.sym]);
          here = NW'(p);
          seen_acc = seen_acc | pat_mask[p];
        end
        rep = here;
      end
      MODE_CLEAR: begin
        wipe_automaton();
        rep = '0;
      end
      default: ;
    endcase
    r.node = rep;
    r.nmask = pat_mask[rep];
    r.seen = seen_acc;
    r.score = weight_sum(seen_acc);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s at cycle %0d: got %0d, expected %0d", what, cycles, got, want);
    errors++;
  endtask

  // Sender: presents items from the feed queue and models each accepted beat.
  always @(posedge clk) begin
    beat_t r;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        step_automaton(cur_item, r);
        due_q.push_back(cur_fixed ? cur_res : r);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (feed_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_item = feed_q.pop_front();
          cur_fixed = fixed_q.pop_front();
          cur_res = fixed_res_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {3'b000, cur_item.wt, cur_item.sym};
          s_axis_tuser <= cur_item.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat against the oldest expectation.
  always @(posedge clk) begin
    beat_t w;
    cycles <= cycles + 1;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_q.size() == 0) begin
          $display("unexpected result beat at cycle %0d", cycles);
          errors++;
        end else begin
          w = due_q.pop_front();
          if (m_axis_tdata[9:0] !== w.node) report("node", m_axis_tdata[9:0], w.node);
          if (m_axis_tdata[19:10] !== w.nmask)
            report("node_mask", m_axis_tdata[19:10], w.nmask);
          if (m_axis_tdata[29:20] !== w.seen)
            report("seen_mask", m_axis_tdata[29:20], w.seen);
          if (m_axis_tdata[44:30] !== w.score)
            report("score", m_axis_tdata[44:30], w.score);
          if (m_axis_tuser !== w.err) report("error", m_axis_tuser, w.err);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // The run is cut off well past the slowest correct completion.
  always @(posedge clk) begin
    if (cycles > 3000000) begin
      $display("multi_pattern_dna_matcher_top test failed");
      $finish;
    end
  end

  task automatic queue_item(input logic [2:0] m, input logic [1:0] s, input logic [10:0] w);
    item_t it;
    beat_t z;
    it.mode = m;
    it.sym = s;
    it.wt = w;
    z = '{default: '0};
    feed_q.push_back(it);
    fixed_q.push_back(0);
    fixed_res_q.push_back(z);
  endtask

  task automatic drain();
    while (feed_q.size() != 0 || s_axis_tvalid || due_q.size() != 0) @(posedge clk);
  endtask

  task automatic queue_weighted_end();
    queue_item(MODE_END, 2'($urandom_range(3)), 11'($signed($urandom_range(2000)) - 1000));
  endtask

  row_t plan [$];
  beat_t zero_res;
  int sent, len;

  initial begin
    zero_res = '{default: '0};
    wipe_automaton();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table: typed results only where they are plain all-zero
    // beats or the links-not-built code right after reset.
    plan = '{
      '{'{MODE_MATCH, 2'd1, 11'd0}, 1, '{0, 0, 0, 0, ERR_LINKS}},
      '{'{3'd5, 2'd3, 11'h7ff}, 1, '{0, 0, 0, 0, ERR_OK}},
      '{'{3'd6, 2'd0, 11'd0}, 1, '{0, 0, 0, 0, ERR_OK}},
      '{'{3'd7, 2'd2, 11'h400}, 1, '{0, 0, 0, 0, ERR_OK}},
      '{'{MODE_SYM, 2'd0, 11'd0}, 0, zero_res},
      '{'{MODE_SYM, 2'd1, 11'd0}, 0, zero_res},
      '{'{MODE_SYM, 2'd2, 11'd0}, 0, zero_res},
      '{'{MODE_END, 2'd0, 11'd1000}, 0, zero_res},
      '{'{MODE_SYM, 2'd1, 11'd0}, 0, zero_res},
      '{'{MODE_SYM, 2'd2, 11'd0}, 0, zero_res},
      '{'{MODE_END, 2'd0, -11'sd1000}, 0, zero_res},
      // Duplicate pattern lands on the same node.
      '{'{MODE_SYM, 2'd1, 11'd0}, 0, zero_res},
      '{'{MODE_SYM, 2'd2, 11'd0}, 0, zero_res},
      '{'{MODE_END, 2'd3, -11'sd1}, 0, zero_res},
      // Empty patterns end at the root; with a one-symbol pattern they fill the pattern slots.
      '{'{MODE_END, 2'd0, 11'd1}, 0, zero_res},
      '{'{MODE_END, 2'd0, 11'd999}, 0, zero_res},
      '{'{MODE_SYM, 2'd3, 11'd0}, 0, zero_res},
      '{'{MODE_END, 2'd0, 11'd555}, 0, zero_res},
      '{'{MODE_END, 2'd0, 11'd2}, 0, zero_res},
      '{'{MODE_END, 2'd0, 11'd4}, 0, zero_res},
      '{'{MODE_END, 2'd0, 11'd8}, 0, zero_res},
      '{'{MODE_END, 2'd0, 11'd16}, 0, zero_res},
      // One pattern too many.
      '{'{MODE_END, 2'd0, 11'd3}, 0, zero_res},
      '{'{MODE_BUILD, 2'd0, 11'd0}, 0, zero_res},
      '{'{MODE_MATCH, 2'd0, 11'd0}, 0, zero_res},
      '{'{MODE_MATCH, 2'd1, 11'd0}, 0, zero_res},
      '{'{MODE_MATCH, 2'd2, 11'd0}, 0, zero_res},
      '{'{MODE_MATCH, 2'd3, 11'd0}, 0, zero_res},
      '{'{MODE_CLEAR, 2'd0, 11'd0}, 1, '{0, 0, 0, 0, ERR_OK}}
    };
    foreach (plan[i]) begin
      feed_q.push_back(plan[i].in);
      fixed_q.push_back(plan[i].fixed);
      fixed_res_q.push_back(plan[i].res);
    end
    drain();

    // Random part in four idling phases: none, sender idle, receiver
    // stalling, and both.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 55 : (ph == 3) ? 20 : 0;
      stall_pct = (ph == 2) ? 55 : (ph == 3) ? 20 : 0;
      if (ph == 0) begin
        // One long pattern runs the node table out.
        for (int i = 0; i < 1030; i++)
          queue_item(MODE_SYM, 2'($urandom_range(3)), 11'($urandom));
        queue_weighted_end();
        queue_item(MODE_BUILD, '0, '0);
        for (int i = 0; i < 30; i++)
          queue_item(MODE_MATCH, 2'($urandom_range(3)), 11'($urandom));
        queue_item(MODE_CLEAR, '0, '0);
      end
      sent = 0;
      while (sent < 75) begin
        case ($urandom_range(19))
          0: begin
            queue_item(MODE_CLEAR, '0, '0);
            sent++;
          end
          1, 2: begin
            queue_item(3'($urandom_range(7)), 2'($urandom_range(3)), 11'($urandom));
            sent++;
          end
          3, 4, 5, 6, 7, 8: begin
            len = $urandom_range(5);
            for (int i = 0; i < len; i++)
              queue_item(MODE_SYM, 2'($urandom_range(3)), 11'($urandom));
            queue_weighted_end();
            sent += len + 1;
          end
          9, 10: begin
            queue_item(MODE_BUILD, '0, '0);
            sent++;
          end
          default: begin
            len = $urandom_range(12, 1);
            for (int i = 0; i < len; i++)
              queue_item(MODE_MATCH, 2'($urandom_range(3)), 11'($urandom));
            sent += len;
          end
        endcase
        while (feed_q.size() > 20) @(posedge clk);
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0 && due_q.size() == 0) begin
      $display("multi_pattern_dna_matcher_top test passed");
    end else begin
      $display("multi_pattern_dna_matcher_top test failed");
    end
    $finish;
  end

endmodule
